// File: hdl/arc_pkg.sv
// Shared types, constants and lookup tables for the aspect ratio classifier.
package arc_pkg;

   // Frame dimension width
   localparam int DIM_BITS    = 16;
   localparam int DIM_CNT_W   = $clog2(DIM_BITS);

   // Prime table geometry
   localparam int NUM_PRIMES  = 25;
   localparam int PRIME_IDX_W = 5;
   localparam int PRIME_W     = 7;

   // Ratio table geometry
   localparam int NUM_RATIOS  = 24;
   localparam int RATIO_IDX_W = 5;
   localparam int ROM_VAL_W   = 10;
   localparam int CODE_W      = 4;
   localparam int CMP_W       = (DIM_BITS > ROM_VAL_W) ? DIM_BITS : ROM_VAL_W;

   // Ratio codes
   localparam logic [CODE_W-1:0] RATIO_1_1    = 4'd0;
   localparam logic [CODE_W-1:0] RATIO_11_9   = 4'd1;
   localparam logic [CODE_W-1:0] RATIO_5_4    = 4'd2;
   localparam logic [CODE_W-1:0] RATIO_4_3    = 4'd3;
   localparam logic [CODE_W-1:0] RATIO_3_2    = 4'd4;
   localparam logic [CODE_W-1:0] RATIO_14_9   = 4'd5;
   localparam logic [CODE_W-1:0] RATIO_8_5    = 4'd6;
   localparam logic [CODE_W-1:0] RATIO_5_3    = 4'd7;
   localparam logic [CODE_W-1:0] RATIO_16_9   = 4'd8;
   localparam logic [CODE_W-1:0] RATIO_9_5    = 4'd9;
   localparam logic [CODE_W-1:0] RATIO_17_9   = 4'd10;
   localparam logic [CODE_W-1:0] RATIO_21_9   = 4'd11;
   localparam logic [CODE_W-1:0] RATIO_UNIQUE = 4'd12;

   // Request and response payloads
   typedef struct packed {
      logic [DIM_BITS-1:0] frame_width;
      logic [DIM_BITS-1:0] frame_height;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]   ratio_code;
      logic [DIM_BITS-1:0] reduced_width;
      logic [DIM_BITS-1:0] reduced_height;
   } rsp_type;

   // Divider control from the sequencer
   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_DECIDE,
      ST_MATCH
   } state_type;

   // One row of the ratio table
   typedef struct packed {
      logic [ROM_VAL_W-1:0] num;
      logic [ROM_VAL_W-1:0] den;
      logic [CODE_W-1:0]    code;
   } ratio_row_type;

   // Primes 2 through 97 in ascending order
   function automatic logic [PRIME_W-1:0] prime_at(input logic [PRIME_IDX_W-1:0] idx);
      logic [PRIME_W-1:0] p;
      unique case (idx)
         5'd0:    p = 7'd2;
         5'd1:    p = 7'd3;
         5'd2:    p = 7'd5;
         5'd3:    p = 7'd7;
         5'd4:    p = 7'd11;
         5'd5:    p = 7'd13;
         5'd6:    p = 7'd17;
         5'd7:    p = 7'd19;
         5'd8:    p = 7'd23;
         5'd9:    p = 7'd29;
         5'd10:   p = 7'd31;
         5'd11:   p = 7'd37;
         5'd12:   p = 7'd41;
         5'd13:   p = 7'd43;
         5'd14:   p = 7'd47;
         5'd15:   p = 7'd53;
         5'd16:   p = 7'd59;
         5'd17:   p = 7'd61;
         5'd18:   p = 7'd67;
         5'd19:   p = 7'd71;
         5'd20:   p = 7'd73;
         5'd21:   p = 7'd79;
         5'd22:   p = 7'd83;
         5'd23:   p = 7'd89;
         5'd24:   p = 7'd97;
         default: p = 7'd2;
      endcase
      return p;
   endfunction

   // Ratio table, scanned in order; first hit wins
   function automatic ratio_row_type ratio_at(input logic [RATIO_IDX_W-1:0] idx);
      ratio_row_type r;
      unique case (idx)
         5'd0:    r = '{num: 10'd1,   den: 10'd1,   code: RATIO_1_1};
         5'd1:    r = '{num: 10'd11,  den: 10'd9,   code: RATIO_11_9};
         5'd2:    r = '{num: 10'd5,   den: 10'd4,   code: RATIO_5_4};
         5'd3:    r = '{num: 10'd4,   den: 10'd3,   code: RATIO_4_3};
         5'd4:    r = '{num: 10'd3,   den: 10'd2,   code: RATIO_3_2};
         5'd5:    r = '{num: 10'd14,  den: 10'd9,   code: RATIO_14_9};
         5'd6:    r = '{num: 10'd8,   den: 10'd5,   code: RATIO_8_5};
         5'd7:    r = '{num: 10'd5,   den: 10'd3,   code: RATIO_5_3};
         5'd8:    r = '{num: 10'd16,  den: 10'd9,   code: RATIO_16_9};
         5'd9:    r = '{num: 10'd9,   den: 10'd5,   code: RATIO_9_5};
         5'd10:   r = '{num: 10'd17,  den: 10'd9,   code: RATIO_17_9};
         5'd11:   r = '{num: 10'd21,  den: 10'd9,   code: RATIO_21_9};
         5'd12:   r = '{num: 10'd683, den: 10'd384, code: RATIO_16_9};
         5'd13:   r = '{num: 10'd85,  den: 10'd48,  code: RATIO_16_9};
         5'd14:   r = '{num: 10'd256, den: 10'd135, code: RATIO_17_9};
         5'd15:   r = '{num: 10'd512, den: 10'd307, code: RATIO_5_3};
         5'd16:   r = '{num: 10'd30,  den: 10'd23,  code: RATIO_4_3};
         5'd17:   r = '{num: 10'd128, den: 10'd69,  code: RATIO_17_9};
         // shadowed by the earlier 30:23 row, kept for table order
         5'd18:   r = '{num: 10'd30,  den: 10'd23,  code: RATIO_11_9};
         5'd19:   r = '{num: 10'd53,  den: 10'd30,  code: RATIO_16_9};
         5'd20:   r = '{num: 10'd37,  den: 10'd30,  code: RATIO_11_9};
         5'd21:   r = '{num: 10'd192, den: 10'd145, code: RATIO_4_3};
         5'd22:   r = '{num: 10'd640, den: 10'd427, code: RATIO_3_2};
         5'd23:   r = '{num: 10'd427, den: 10'd240, code: RATIO_16_9};
         default: r = '{num: 10'd0,   den: 10'd0,   code: RATIO_UNIQUE};
      endcase
      return r;
   endfunction

endpackage

// File: hdl/arc_serial_div.sv
// Bit-serial restoring divider of one dimension by a small prime, MSB first.
module arc_serial_div (
   input  logic                         clock,
   input  arc_pkg::div_ctrl_type        ctrl,
   input  logic [arc_pkg::DIM_BITS-1:0] load_value,
   input  logic [arc_pkg::PRIME_W-1:0]  prime,
   output logic [arc_pkg::DIM_BITS-1:0] quotient,
   output logic                         rem_zero
);
   import arc_pkg::*;

   logic [DIM_BITS-1:0] shift_ff, shift_in;
   logic [PRIME_W-1:0]  rem_ff, rem_in;
   logic [PRIME_W:0]    rem_wide;
   logic                q_bit;

   // One quotient bit per step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_wide = {rem_ff, shift_ff[DIM_BITS-1]};
      q_bit    = (rem_wide >= {1'b0, prime});
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (ctrl.load) begin
         shift_in = load_value;
         rem_in   = '0;
      end else if (ctrl.step) begin
         shift_in = {shift_ff[DIM_BITS-2:0], q_bit};
         rem_in   = q_bit ? PRIME_W'(rem_wide - {1'b0, prime}) : PRIME_W'(rem_wide);
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   // Dividend bits leave at the top while quotient bits fill from the bottom
   assign quotient = shift_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

// File: hdl/arc_ratio_match.sv
// Sequential scan of the ratio table, one row per cycle, first hit wins.
module arc_ratio_match (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [arc_pkg::DIM_BITS-1:0] dim_w,
   input  logic [arc_pkg::DIM_BITS-1:0] dim_h,
   output logic                         done,
   output logic [arc_pkg::CODE_W-1:0]   code
);
   import arc_pkg::*;

   logic                   scan_ff, scan_in;
   logic                   done_ff, done_in;
   logic [RATIO_IDX_W-1:0] idx_ff, idx_in;
   logic [CODE_W-1:0]      code_ff, code_in;
   ratio_row_type          row;
   logic                   hit;
   logic                   last_row;

   // Compare the current row against the reduced pair
   always_comb begin
      row      = ratio_at(idx_ff);
      hit      = (CMP_W'(dim_w) == CMP_W'(row.num)) && (CMP_W'(dim_h) == CMP_W'(row.den));
      last_row = (idx_ff == RATIO_IDX_W'(NUM_RATIOS - 1));
   end

   // Scan control
   always_comb begin
      scan_in = scan_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      code_in = code_ff;
      if (start) begin
         scan_in = 1'b1;
         idx_in  = '0;
      end else if (scan_ff) begin
         if (hit) begin
            scan_in = 1'b0;
            done_in = 1'b1;
            code_in = row.code;
         end else if (last_row) begin
            scan_in = 1'b0;
            done_in = 1'b1;
            code_in = RATIO_UNIQUE;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         scan_ff <= scan_in;
         done_ff <= done_in;
      end
      idx_ff  <= idx_in;
      code_ff <= code_in;
   end

   assign done = done_ff;
   assign code = code_ff;

   // Done is a single pulse that closes a scan
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("match done held longer than one cycle");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !scan_ff)
      else $error("scan still running after done");
   assert property (@(posedge clock) disable iff (reset)
      (done_ff && (code_ff != RATIO_UNIQUE)) |-> $past(hit))
      else $error("ratio code reported without a table hit");

endmodule

// File: hdl/aspect_ratio_classifier_core.sv
// Sequence: after a request is accepted each prime is tried in turn by a load, a bit-serial
//   divide and a decide step, the same prime again while it divides both nonzero dimensions;
//   the ratio table is then scanned row by row until a hit or its last row.
// Throughput: one request at a time, set by the two bit-serial dividers at one bit per cycle;
//   busy holds from acceptance until the one-cycle result strobe; the receiver cannot stall.
// Reset: synchronous, active high; returns to idle, no result pending.
module aspect_ratio_classifier_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  arc_pkg::req_type req_data,
   output logic             rsp_valid,
   output arc_pkg::rsp_type rsp_data
);
   import arc_pkg::*;

   state_type              state_ff, state_in;
   logic [DIM_BITS-1:0]    w_ff, w_in;
   logic [DIM_BITS-1:0]    h_ff, h_in;
   logic [PRIME_IDX_W-1:0] prime_idx_ff, prime_idx_in;
   logic [DIM_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   div_ctrl_type           div_ctrl;
   logic [DIM_BITS-1:0]    w_quot, h_quot;
   logic                   w_rem_zero, h_rem_zero;
   logic                   match_done;
   logic [CODE_W-1:0]      match_code;
   logic [PRIME_W-1:0]     prime;

   logic                   accept;
   logic                   last_bit;
   logic                   last_prime;
   logic                   reduce;
   logic                   take_quot;
   logic                   prime_next;
   logic                   match_start;

   assign prime      = prime_at(prime_idx_ff);
   assign last_bit   = (bit_cnt_ff == DIM_CNT_W'(DIM_BITS - 1));
   assign last_prime = (prime_idx_ff == PRIME_IDX_W'(NUM_PRIMES - 1));
   // both divisible and nonzero means both at least the prime
   assign reduce     = w_rem_zero && h_rem_zero && (|w_ff) && (|h_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (last_bit) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (reduce || !last_prime) state_in = ST_LOAD;
            else state_in = ST_MATCH;
         end
         ST_MATCH:  if (match_done) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      accept      = 1'b0;
      div_ctrl    = '0;
      take_quot   = 1'b0;
      prime_next  = 1'b0;
      match_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:   accept = start;
         ST_LOAD:   div_ctrl.load = 1'b1;
         ST_DIVIDE: div_ctrl.step = 1'b1;
         ST_DECIDE: begin
            take_quot   = reduce;
            prime_next  = !reduce && !last_prime;
            match_start = !reduce && last_prime;
         end
         ST_MATCH:  ;
         default:   ;
      endcase
   end

   // Working pair, prime index, bit counter and result register
   always_comb begin
      w_in         = w_ff;
      h_in         = h_ff;
      prime_idx_in = prime_idx_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (accept) begin
         w_in         = req_data.frame_width;
         h_in         = req_data.frame_height;
         prime_idx_in = '0;
      end
      if (take_quot) begin
         w_in = w_quot;
         h_in = h_quot;
      end
      if (prime_next) prime_idx_in = prime_idx_ff + 1'b1;
      if (div_ctrl.load) bit_cnt_in = '0;
      else if (div_ctrl.step) bit_cnt_in = bit_cnt_ff + 1'b1;
      if ((state_ff == ST_MATCH) && match_done) begin
         rsp_valid_in          = 1'b1;
         rsp_in.ratio_code     = match_code;
         rsp_in.reduced_width  = w_ff;
         rsp_in.reduced_height = h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff         <= w_in;
      h_ff         <= h_in;
      prime_idx_ff <= prime_idx_in;
      bit_cnt_ff   <= bit_cnt_in;
      rsp_ff       <= rsp_in;
   end

   // Width and height dividers run in lockstep
   arc_serial_div u_div_w (
      .clock      (clock),
      .ctrl       (div_ctrl),
      .load_value (w_ff),
      .prime      (prime),
      .quotient   (w_quot),
      .rem_zero   (w_rem_zero)
   );

   arc_serial_div u_div_h (
      .clock      (clock),
      .ctrl       (div_ctrl),
      .load_value (h_ff),
      .prime      (prime),
      .quotient   (h_quot),
      .rem_zero   (h_rem_zero)
   );

   arc_ratio_match u_match (
      .clock (clock),
      .reset (reset),
      .start (match_start),
      .dim_w (w_ff),
      .dim_h (h_ff),
      .done  (match_done),
      .code  (match_code)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A request ends in exactly one result strobe as busy drops
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while still busy");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && reduce) |=> (w_ff != '0 && h_ff != '0))
      else $error("reduction produced a zero dimension");

endmodule
